>>> rtl/core/emlc_pkg.sv
`default_nettype none

package emlc_pkg;

  localparam int unsigned CDF_W   = 17;
  localparam int unsigned TOTAL_W = 47;
  localparam int unsigned CHAN_W  = 16;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned WEIGHT_W   = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd13933;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd46872;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd4732;

  localparam int unsigned WIDTH_RST  = 256;
  localparam int unsigned HEIGHT_RST = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD       = 2'd0,
    CMD_READ_MARG  = 2'd1,
    CMD_READ_COND  = 2'd2,
    CMD_READ_TOTAL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_RANGE     = 2'd2,
    ST_ZERO_SUM  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CDF_W-1:0]   cdf_value;
    logic [TOTAL_W-1:0] total_luminance;
    status_e            status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/emlc_fifo.sv
`default_nettype none

module emlc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (32'(cnt_q) == DEPTH);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/emlc_front.sv
`default_nettype none

module emlc_front #(
  parameter int unsigned CHANNEL_BITS = 16,
  parameter int unsigned YW           = 32,
  parameter int unsigned IW           = 49
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [emlc_pkg::CMD_W-1:0]  command_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0] red_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0] green_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0] blue_i,
  input  wire logic [emlc_pkg::COL_W-1:0]  col_index_i,
  input  wire logic [emlc_pkg::ROW_W-1:0]  row_index_i,
  output logic                            mid_push_o,
  output logic [IW-1:0]                   mid_item_o,
  input  wire logic                       mid_full_i,
  output logic                            idle_o
);
  import emlc_pkg::*;

  logic [CHANNEL_BITS+CHAN_W-1:0] r_ext, g_ext, b_ext;
  logic [YW-1:0]                  luma;
  logic                           s_valid_q;
  logic [IW-1:0]                  s_item_q;
  logic                           accept;

  assign r_ext = {{CHANNEL_BITS{1'b0}}, red_i};
  assign g_ext = {{CHANNEL_BITS{1'b0}}, green_i};
  assign b_ext = {{CHANNEL_BITS{1'b0}}, blue_i};

  assign luma = YW'(r_ext[CHANNEL_BITS-1:0]) * YW'(WEIGHT_R)
              + YW'(g_ext[CHANNEL_BITS-1:0]) * YW'(WEIGHT_G)
              + YW'(b_ext[CHANNEL_BITS-1:0]) * YW'(WEIGHT_B);

  assign full       = s_valid_q && mid_full_i;
  assign accept     = push && !full;
  assign mid_push_o = s_valid_q && !mid_full_i;
  assign mid_item_o = s_item_q;
  assign idle_o     = !s_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_item_q <= {command_i, luma, col_index_i, row_index_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (accept) begin
      s_valid_q <= 1'b1;
    end else if (mid_push_o) begin
      s_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/emlc_div.sv
`default_nettype none

module emlc_div #(
  parameter int unsigned TW = 47,
  parameter int unsigned F  = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [TW-1:0] p_i,
  input  wire logic [TW-1:0] s_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [F:0]         q_o
);

  localparam int unsigned NW = $clog2(F + 1);

  logic          busy_q, done_q;
  logic [NW-1:0] cnt_q;
  logic [TW:0]   rem_q;
  logic [TW-1:0] s_q;
  logic [F:0]    q_q;
  logic [TW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[TW-1:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, s_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        s_q <= s_i;
        if (s_i == '0) begin
          q_q    <= '0;
          done_q <= 1'b1;
        end else if (p_i >= s_i) begin
          q_q    <= (F+1)'(1) << F;
          done_q <= 1'b1;
        end else begin
          q_q    <= '0;
          rem_q  <= {1'b0, p_i};
          cnt_q  <= NW'(F);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= ge ? (rem_sh - {1'b0, s_q}) : rem_sh;
        q_q   <= {q_q[F-1:0], ge};
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/emlc_back.sv
`default_nettype none

module emlc_back #(
  parameter int unsigned MAX_WIDTH     = 256,
  parameter int unsigned MAX_HEIGHT    = 128,
  parameter int unsigned CDF_FRAC_BITS = 16,
  parameter int unsigned YW            = 32,
  parameter int unsigned IW            = 49
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [emlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [emlc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          mid_empty_i,
  input  wire logic [IW-1:0]                 mid_item_i,
  output logic                               mid_pop_o,
  input  wire logic                          out_full_i,
  output logic                               out_push_o,
  output emlc_pkg::res_t                     out_res_o,
  output logic                               idle_o
);
  import emlc_pkg::*;

  localparam int unsigned F     = CDF_FRAC_BITS;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CSW   = YW + $clog2(MAX_HEIGHT);
  localparam int unsigned TW    = YW + $clog2(DEPTH);
  localparam int unsigned W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int unsigned H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_RD_WAIT, S_RD_RESP,
    S_BU_COL, S_BU_CS, S_BU_LRD, S_BU_ADD, S_BU_CDIV, S_BU_MDIV
  } state_e;

  state_e          state_q;
  logic [WW-1:0]   w_q;
  logic [HW-1:0]   h_q;
  logic [CW-1:0]   pc_q, u_q;
  logic [RW-1:0]   pr_q, v_q;
  logic [AW-1:0]   base_q, bu_addr_q;
  logic [TW-1:0]   total_q, colpre_q;
  logic            ready_q;
  cmd_e            cmd_q;
  logic [YW-1:0]   luma_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [CSW-1:0]  rowpre_q, colsum_q;

  logic [YW-1:0]   luma_mem [DEPTH];
  logic [F:0]      cond_mem [DEPTH];
  logic [CSW-1:0]  cs_mem   [MAX_WIDTH];
  logic [F:0]      marg_mem [MAX_WIDTH];
  logic [YW-1:0]   luma_rd_q;
  logic [F:0]      cond_rd_q, marg_rd_q;
  logic [CSW-1:0]  cs_rd_q;

  logic [CW-1:0]   cs_raddr;
  logic [AW-1:0]   cond_raddr;
  logic [CSW-1:0]  cs_new, rowpre_nx;
  logic [TW-1:0]   colpre_nx, div_p, div_s;
  logic            luma_we, cs_we, cond_we, marg_we;
  logic            last_pc, last_pr, last_row, last_col;
  logic            div_start, div_busy, div_done;
  logic [F:0]      div_q;
  logic            col_bad, row_bad;
  res_t            res_rd;

  emlc_div #(.TW(TW), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (div_p),
    .s_i     (div_s),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign last_pc  = (32'(pc_q) == 32'(w_q) - 32'd1);
  assign last_pr  = (32'(pr_q) == 32'(h_q) - 32'd1);
  assign last_col = (32'(u_q) == 32'(w_q) - 32'd1);
  assign last_row = (32'(v_q) == 32'(h_q) - 32'd1);
  assign col_bad  = (32'(col_q) >= 32'(w_q));
  assign row_bad  = (32'(row_q) >= 32'(h_q));

  assign mid_pop_o = (state_q == S_IDLE) && !mid_empty_i && !out_full_i && !cfg_we_i;
  assign idle_o    = (state_q == S_IDLE) && mid_empty_i;

  always_comb begin
    priority if (state_q == S_LD_RD) cs_raddr = pc_q;
    else if (state_q == S_BU_COL)    cs_raddr = u_q;
    else                             cs_raddr = CW'(col_q);
  end

  assign cond_raddr = AW'(32'(row_q) * 32'(MAX_WIDTH) + 32'(col_q));

  assign cs_new    = (pr_q == '0) ? CSW'(luma_q) : cs_rd_q + CSW'(luma_q);
  assign rowpre_nx = rowpre_q + CSW'(luma_rd_q);
  assign colpre_nx = colpre_q + TW'(colsum_q);

  assign luma_we = (state_q == S_LD_WR);
  assign cs_we   = (state_q == S_LD_WR);
  assign cond_we = (state_q == S_BU_CDIV) && div_done;
  assign marg_we = (state_q == S_BU_MDIV) && div_done;

  assign div_start = (state_q == S_BU_ADD) || ((state_q == S_BU_CDIV) && div_done && last_row);
  assign div_p     = (state_q == S_BU_ADD) ? TW'(rowpre_nx) : colpre_nx;
  assign div_s     = (state_q == S_BU_ADD) ? TW'(colsum_q) : total_q;

  always_comb begin
    res_rd = '{cdf_value: '0, total_luminance: '0, status: ST_OK};
    if (!ready_q) begin
      res_rd.status = ST_NOT_READY;
    end else begin
      unique case (cmd_q)
        CMD_READ_MARG: begin
          if (col_bad) res_rd.status = ST_RANGE;
          else if (total_q == '0) res_rd.status = ST_ZERO_SUM;
          else res_rd.cdf_value = CDF_W'(marg_rd_q);
        end
        CMD_READ_COND: begin
          if (col_bad || row_bad) res_rd.status = ST_RANGE;
          else if (cs_rd_q == '0) res_rd.status = ST_ZERO_SUM;
          else res_rd.cdf_value = CDF_W'(cond_rd_q);
        end
        CMD_READ_TOTAL: begin
          res_rd.total_luminance = TOTAL_W'(total_q);
          if (total_q == '0) res_rd.status = ST_ZERO_SUM;
        end
        CMD_LOAD: res_rd.status = ST_OK;
        default:  res_rd.status = ST_OK;
      endcase
    end
  end

  assign out_push_o = ((state_q == S_LD_WR) && !(last_pc && last_pr))
                   || (state_q == S_RD_RESP)
                   || ((state_q == S_BU_MDIV) && div_done && last_col);
  assign out_res_o  = (state_q == S_RD_RESP) ? res_rd
                    : '{cdf_value: '0, total_luminance: '0, status: ST_OK};

  always_ff @(posedge clk_i) begin
    if (luma_we) luma_mem[base_q + AW'(pc_q)] <= luma_q;
    luma_rd_q <= luma_mem[bu_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cond_we) cond_mem[bu_addr_q] <= div_q;
    cond_rd_q <= cond_mem[cond_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[pc_q] <= cs_new;
    cs_rd_q <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (marg_we) marg_mem[u_q] <= div_q;
    marg_rd_q <= marg_mem[CW'(col_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      w_q       <= WW'(W_RST);
      h_q       <= HW'(H_RST);
      pc_q      <= '0;
      pr_q      <= '0;
      base_q    <= '0;
      total_q   <= '0;
      ready_q   <= 1'b0;
      u_q       <= '0;
      v_q       <= '0;
      bu_addr_q <= '0;
      colpre_q  <= '0;
      rowpre_q  <= '0;
      colsum_q  <= '0;
      cmd_q     <= CMD_LOAD;
      luma_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT) begin
              if (cfg_index_i == CFG_IMAGE_WIDTH) begin
                if (cfg_data_i == '0) w_q <= WW'(1);
                else if (32'(cfg_data_i) > MAX_WIDTH) w_q <= WW'(MAX_WIDTH);
                else w_q <= WW'(cfg_data_i);
              end else begin
                if (cfg_data_i[7:0] == '0) h_q <= HW'(1);
                else if (32'(cfg_data_i[7:0]) > MAX_HEIGHT) h_q <= HW'(MAX_HEIGHT);
                else h_q <= HW'(cfg_data_i[7:0]);
              end
              pc_q    <= '0;
              pr_q    <= '0;
              base_q  <= '0;
              total_q <= '0;
              ready_q <= 1'b0;
            end
          end else if (mid_pop_o) begin
            cmd_q  <= cmd_e'(mid_item_i[IW-1 -: CMD_W]);
            luma_q <= mid_item_i[YW+COL_W+ROW_W-1 -: YW];
            col_q  <= mid_item_i[COL_W+ROW_W-1 -: COL_W];
            row_q  <= mid_item_i[ROW_W-1:0];
            if (cmd_e'(mid_item_i[IW-1 -: CMD_W]) == CMD_LOAD) begin
              if (ready_q) begin
                pc_q    <= '0;
                pr_q    <= '0;
                base_q  <= '0;
                total_q <= '0;
                ready_q <= 1'b0;
              end
              state_q <= S_LD_RD;
            end else begin
              state_q <= S_RD_WAIT;
            end
          end
        end
        S_LD_RD: state_q <= S_LD_WR;
        S_LD_WR: begin
          total_q <= total_q + TW'(luma_q);
          if (last_pc) begin
            pc_q <= '0;
            if (last_pr) begin
              pr_q      <= '0;
              base_q    <= '0;
              u_q       <= '0;
              v_q       <= '0;
              bu_addr_q <= '0;
              colpre_q  <= '0;
              state_q   <= S_BU_COL;
            end else begin
              pr_q    <= pr_q + RW'(1);
              base_q  <= base_q + AW'(MAX_WIDTH);
              state_q <= S_IDLE;
            end
          end else begin
            pc_q    <= pc_q + CW'(1);
            state_q <= S_IDLE;
          end
        end
        S_RD_WAIT: state_q <= S_RD_RESP;
        S_RD_RESP: state_q <= S_IDLE;
        S_BU_COL:  state_q <= S_BU_CS;
        S_BU_CS: begin
          colsum_q <= cs_rd_q;
          rowpre_q <= '0;
          state_q  <= S_BU_ADD;
        end
        S_BU_LRD: state_q <= S_BU_ADD;
        S_BU_ADD: begin
          rowpre_q <= rowpre_nx;
          state_q  <= S_BU_CDIV;
        end
        S_BU_CDIV: begin
          if (div_done) begin
            if (last_row) begin
              colpre_q <= colpre_nx;
              state_q  <= S_BU_MDIV;
            end else begin
              v_q       <= v_q + RW'(1);
              bu_addr_q <= bu_addr_q + AW'(MAX_WIDTH);
              state_q   <= S_BU_LRD;
            end
          end
        end
        S_BU_MDIV: begin
          if (div_done) begin
            if (last_col) begin
              ready_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              u_q       <= u_q + CW'(1);
              v_q       <= '0;
              bu_addr_q <= AW'(u_q) + AW'(1);
              state_q   <= S_BU_COL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into a full queue");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_ready_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (pc_q == '0 && pr_q == '0))
    else $error("load cursor not rewound with tables ready");

  a_ready_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> ($past(state_q) == S_BU_MDIV))
    else $error("tables marked ready outside the build");

endmodule

`default_nettype wire

>>> rtl/core/env_map_luminance_cdf_builder.sv
// Load word: front stage, queue, then read-modify-write of the tables.
// The word that completes the image is answered after the table build, which
// runs the iterative divider for every table entry.
// Read words: front stage, queue, table read; one word in the back end at a time.
// Reset (asynchronous, active low) clears control, sums and the ready flag;
// column sums fill as the first row loads, so no clearing pass runs.
`default_nettype none

module env_map_luminance_cdf_builder #(
  parameter int unsigned MAX_WIDTH     = 256,
  parameter int unsigned MAX_HEIGHT    = 128,
  parameter int unsigned CHANNEL_BITS  = 16,
  parameter int unsigned CDF_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [emlc_pkg::CMD_W-1:0]       command_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0]      red_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0]      green_i,
  input  wire logic [emlc_pkg::CHAN_W-1:0]      blue_i,
  input  wire logic [emlc_pkg::COL_W-1:0]       col_index_i,
  input  wire logic [emlc_pkg::ROW_W-1:0]       row_index_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [emlc_pkg::CDF_W-1:0]            cdf_value_o,
  output logic [emlc_pkg::TOTAL_W-1:0]          total_luminance_o,
  output logic [1:0]                           status_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [emlc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [emlc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import emlc_pkg::*;

  localparam int unsigned YW = (CHANNEL_BITS > 16) ? CHANNEL_BITS + 17 : CHANNEL_BITS + 16;
  localparam int unsigned IW = CMD_W + YW + COL_W + ROW_W;
  localparam int unsigned RESW = $bits(res_t);

  logic          mid_push, mid_full, mid_empty, mid_pop;
  logic [IW-1:0] mid_in, mid_out;
  logic          out_push, out_full;
  res_t          out_res, out_head;
  logic [RESW-1:0] out_head_raw;
  logic          front_idle, back_idle, cfg_we;

  assign cfg_ready_o = front_idle && back_idle;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  emlc_front #(.CHANNEL_BITS(CHANNEL_BITS), .YW(YW), .IW(IW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .col_index_i (col_index_i),
    .row_index_i (row_index_i),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in),
    .mid_full_i  (mid_full),
    .idle_o      (front_idle)
  );

  emlc_fifo #(.W(IW), .DEPTH(2)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  emlc_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .CDF_FRAC_BITS (CDF_FRAC_BITS),
    .YW            (YW),
    .IW            (IW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_res_o   (out_res),
    .idle_o      (back_idle)
  );

  emlc_fifo #(.W(RESW), .DEPTH(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_head_raw),
    .empty_o (empty)
  );

  assign out_head          = res_t'(out_head_raw);
  assign cdf_value_o       = out_head.cdf_value;
  assign total_luminance_o = out_head.total_luminance;
  assign status_o          = out_head.status;

endmodule

`default_nettype wire
